// ----- rtl/tpct_pkg.sv -----
// Shared types and constants for the two-point calibration table.
`default_nettype none
package tpct_pkg;

   typedef enum logic [1:0] {
      ACT_CALIBRATE = 2'd0,
      ACT_VALUE_TO_CODE = 2'd1,
      ACT_CODE_TO_VALUE = 2'd2,
      ACT_CLEAR = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_OK = 2'd0,
      ST_BAD_INDEX = 2'd1,
      ST_NOT_CAL = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_READ,
      S_DIV_LOAD,
      S_DIV,
      S_SLOPE,
      S_MUL,
      S_FINISH
   } state_type;

   typedef struct packed {
      action_type action;
      logic [3:0] axis;
      logic [2:0] mode;
      logic [15:0] first_code;
      logic signed [31:0] first_value;
      logic [15:0] second_code;
      logic signed [31:0] second_value;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [15:0] code_out;
      logic signed [31:0] value_out;
      logic calibrated;
   } rsp_type;

   typedef struct packed {
      logic load_item;
      logic mem_read;
      logic div_load;
      logic div_step;
      logic slope_load;
      logic mul_load;
      logic finish;
   } cmd_type;

   typedef struct packed {
      action_type action;
      logic bad_index;
      logic entry_valid;
      logic div_last;
      logic out_free;
   } stat_type;

   localparam int DIV_STEPS = 64;
   localparam logic [15:0] MAX_CODE_RESET = 16'hFFFF;
   localparam logic [16:0] CODE_MARGIN = 17'd8;

endpackage
`default_nettype wire

// ----- rtl/tpct_ctrl.sv -----
// Sequencer that steps the datapath through one item at a time.
`default_nettype none
module tpct_ctrl
   import tpct_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire stat_type stat,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (stat.action == ACT_CLEAR || stat.bad_index) begin
               state_in = S_FINISH;
            end else if (stat.action == ACT_CALIBRATE) begin
               state_in = S_DIV_LOAD;
            end else if (!stat.entry_valid) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            if (stat.action == ACT_VALUE_TO_CODE) begin
               state_in = S_DIV_LOAD;
            end else begin
               state_in = S_MUL;
            end
         end
         S_DIV_LOAD: state_in = S_DIV;
         S_DIV: begin
            if (stat.div_last) begin
               if (stat.action == ACT_CALIBRATE) begin
                  state_in = S_SLOPE;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_SLOPE: state_in = S_MUL;
         S_MUL: state_in = S_FINISH;
         S_FINISH: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            cmd.load_item = req_valid;
         end
         S_READ: cmd.mem_read = 1'b1;
         S_DIV_LOAD: cmd.div_load = 1'b1;
         S_DIV: cmd.div_step = 1'b1;
         S_SLOPE: cmd.slope_load = 1'b1;
         S_MUL: cmd.mul_load = 1'b1;
         S_FINISH: cmd.finish = stat.out_free;
         default: cmd = '0;
      endcase
   end

endmodule
`default_nettype wire

// ----- rtl/tpct_datapath.sv -----
// Calibration store, shared divider, multiplier and result register.
`default_nettype none
module tpct_datapath
   import tpct_pkg::*;
#(
   parameter int AXES = 4,
   parameter int MODES = 4
) (
   input wire logic clock,
   input wire logic reset,
   input wire req_type req_data,
   input wire logic csr_valid,
   input wire logic [15:0] csr_data,
   input wire cmd_type cmd,
   output stat_type stat,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output rsp_type rsp_data
);

   localparam int ENTRIES = AXES * MODES;
   localparam int ENTRY_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic [47:0] slope_mem [ENTRIES];
   logic [47:0] offset_mem [ENTRIES];
   logic [ENTRIES-1:0] valid_ff, valid_in;

   req_type item_ff;
   logic [15:0] max_code_ff;
   logic [47:0] slope_ff;
   logic [47:0] offset_ff;
   logic slope_err_ff;
   logic [63:0] quo_ff;
   logic [47:0] rem_ff;
   logic [47:0] dsr_ff;
   logic [5:0] div_cnt_ff;
   logic neg_ff;
   logic signed [64:0] prod_ff;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic bad_index;
   logic [ENTRY_W-1:0] entry;
   logic write_ok;
   logic [50:0] off_new;

   logic signed [32:0] dv;
   logic signed [16:0] dc;
   logic [32:0] dv_mag;
   logic [16:0] dc_mag;
   logic signed [48:0] num;
   logic signed [48:0] num2;
   logic [48:0] num_mag;
   logic [47:0] smag;
   logic [63:0] dividend;
   logic [47:0] divisor;
   logic div_neg;

   logic [48:0] rem_sh;
   logic [48:0] rem_diff;
   logic rem_ge;
   logic half_ge;
   logic half_gt;

   logic [64:0] mag;
   logic mag_err;
   logic [47:0] slope_new;

   logic signed [64:0] prod_in;
   logic signed [47:0] slope_s;
   logic signed [16:0] code_s;

   function automatic logic [50:0] rsp_offset(input logic signed [31:0] v1,
                                             input logic signed [64:0] p);
      logic signed [65:0] rnd;
      logic signed [50:0] res;
      begin
         rnd = {p[64], p} + 66'sd32768;
         res = {{19{v1[31]}}, v1} - {rnd[65], rnd[65:16]};
         return res;
      end
   endfunction

   assign bad_index = ({1'b0, item_ff.axis} >= 5'(AXES)) ||
                      ({1'b0, item_ff.mode} >= 4'(MODES));
   assign entry = ENTRY_W'(int'(item_ff.axis) * MODES + int'(item_ff.mode));
   assign off_new = rsp_offset(item_ff.first_value, prod_ff);

   assign stat.action = item_ff.action;
   assign stat.bad_index = bad_index;
   assign stat.entry_valid = valid_ff[entry];
   assign stat.div_last = (div_cnt_ff == 6'(DIV_STEPS - 1));
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_code_ff <= MAX_CODE_RESET;
      end else if (csr_valid) begin
         max_code_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish && write_ok) begin
         slope_mem[entry] <= slope_ff;
         offset_mem[entry] <= off_new[47:0];
      end
      if (cmd.mem_read) begin
         slope_ff <= slope_mem[entry];
         offset_ff <= offset_mem[entry];
      end else if (cmd.slope_load) begin
         slope_ff <= slope_new;
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.finish) begin
         if (item_ff.action == ACT_CLEAR) begin
            valid_in = '0;
         end else if (write_ok) begin
            valid_in[entry] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      dv = {item_ff.second_value[31], item_ff.second_value} -
           {item_ff.first_value[31], item_ff.first_value};
      dc = {1'b0, item_ff.second_code} - {1'b0, item_ff.first_code};
      dv_mag = dv[32] ? 33'(-dv) : 33'(dv);
      dc_mag = dc[16] ? 17'(-dc) : 17'(dc);
      num = {{17{item_ff.first_value[31]}}, item_ff.first_value} -
            {offset_ff[47], offset_ff};
      num2 = slope_ff[47] ? -num : num;
      smag = slope_ff[47] ? 48'(-slope_ff) : slope_ff;
      num_mag = num2[48] ? 49'(-num2) : 49'(num2);
      if (item_ff.action == ACT_CALIBRATE) begin
         dividend = 64'({dv_mag, 16'h0000});
         divisor = 48'(dc_mag);
         div_neg = dv[32] ^ dc[16];
      end else begin
         dividend = {num_mag[47:0], 16'h0000};
         divisor = smag;
         div_neg = num2[48];
      end
   end

   assign rem_sh = {rem_ff, quo_ff[63]};
   assign rem_diff = rem_sh - {1'b0, dsr_ff};
   assign rem_ge = (rem_sh >= {1'b0, dsr_ff});
   assign half_ge = ({rem_ff, 1'b0} >= {1'b0, dsr_ff});
   assign half_gt = ({rem_ff, 1'b0} > {1'b0, dsr_ff});

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dsr_ff <= divisor;
         neg_ff <= div_neg;
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[62:0], rem_ge};
         rem_ff <= rem_ge ? rem_diff[47:0] : rem_sh[47:0];
         div_cnt_ff <= div_cnt_ff + 6'd1;
      end
   end

   always_comb begin
      mag = {1'b0, quo_ff} + 65'(half_ge);
      if (mag == '0) begin
         mag_err = 1'b1;
      end else if (neg_ff) begin
         mag_err = (mag > 65'h8000_0000_0000);
      end else begin
         mag_err = (mag > 65'h7FFF_FFFF_FFFF);
      end
      slope_new = neg_ff ? 48'(-mag[47:0]) : mag[47:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.slope_load) begin
         slope_err_ff <= mag_err;
      end
   end

   assign slope_s = slope_ff;
   assign code_s = {1'b0, item_ff.first_code};
   assign prod_in = slope_s * code_s;

   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         prod_ff <= prod_in;
      end
   end

   always_comb begin
      logic [50:0] off;
      logic signed [50:0] val;
      logic [64:0] q2;
      logic [16:0] limit;
      rsp_in = '0;
      write_ok = 1'b0;
      off = off_new;
      val = {{2{prod_ff[64]}}, prod_ff[64:16]} + {{3{offset_ff[47]}}, offset_ff} +
            51'(prod_ff[15]);
      q2 = {1'b0, quo_ff} + 65'(neg_ff ? half_gt : half_ge);
      limit = {1'b0, max_code_ff} + CODE_MARGIN;
      if (item_ff.action == ACT_CLEAR) begin
         rsp_in.status = ST_OK;
      end else if (bad_index) begin
         rsp_in.status = ST_BAD_INDEX;
      end else if (item_ff.action == ACT_CALIBRATE) begin
         if (item_ff.first_code == item_ff.second_code || slope_err_ff ||
             !(off[50:47] == 4'b0000 || off[50:47] == 4'b1111)) begin
            rsp_in.status = ST_RANGE;
         end else begin
            rsp_in.status = ST_OK;
            write_ok = 1'b1;
         end
         rsp_in.calibrated = valid_ff[entry] || write_ok;
      end else if (!valid_ff[entry]) begin
         rsp_in.status = ST_NOT_CAL;
      end else if (item_ff.action == ACT_VALUE_TO_CODE) begin
         rsp_in.calibrated = 1'b1;
         if (dsr_ff == '0) begin
            rsp_in.status = ST_RANGE;
         end else if (neg_ff) begin
            rsp_in.status = (q2 > 65'(CODE_MARGIN)) ? ST_RANGE : ST_OK;
         end else if (q2 > 65'(limit)) begin
            rsp_in.status = ST_RANGE;
         end else begin
            rsp_in.status = ST_OK;
            rsp_in.code_out = (q2 > 65'(max_code_ff)) ? max_code_ff : q2[15:0];
         end
      end else begin
         rsp_in.calibrated = 1'b1;
         rsp_in.status = ST_OK;
         if (!val[50] && val[50:31] != '0) begin
            rsp_in.value_out = 32'sh7FFF_FFFF;
         end else if (val[50] && val[50:31] != '1) begin
            rsp_in.value_out = 32'sh8000_0000;
         end else begin
            rsp_in.value_out = val[31:0];
         end
      end
   end

   assign rsp_valid_in = cmd.finish || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

// ----- rtl/two_point_calibration_table.sv -----
// Top level of the two-point calibration table.
`default_nettype none
// Stores one slope and offset per axis and mode and converts codes to values and back.
// One item is processed at a time. Calibrate and value to code both run a 64-step radix-2
// divider shared by the two. A result waiting in the output register does not stop the next
// item from being accepted, but that item holds its result until the output register is
// free. The calibrated flags are cleared at reset. The max_code register can be written at
// any time through the csr port, which never stalls.
module two_point_calibration_table
   import tpct_pkg::*;
#(
   parameter int AXES = 4,
   parameter int MODES = 4
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_stall,
   input wire req_type req_data,
   output logic rsp_valid,
   input wire logic rsp_stall,
   output rsp_type rsp_data,
   input wire logic csr_valid,
   output logic csr_ready,
   input wire logic [15:0] csr_data
);

   cmd_type cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   tpct_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .stat(stat),
      .cmd(cmd)
   );

   tpct_datapath #(
      .AXES(AXES),
      .MODES(MODES)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .req_data(req_data),
      .csr_valid(csr_valid),
      .csr_data(csr_data),
      .cmd(cmd),
      .stat(stat),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("Input was not stalled after an item was accepted.");

   a_bad_index_uncal: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == ST_BAD_INDEX) |-> !rsp_data.calibrated)
      else $error("Bad index item reported a calibrated entry.");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |->
      (rsp_data.code_out == '0 && rsp_data.value_out == '0))
      else $error("Failed item carried a nonzero result.");
`endif

endmodule
`default_nettype wire
